// ===== design/nec_tx_pkg.sv =====
// Shared types and constants for the NEC IR frame transmitter.
`timescale 1ns / 1ps
`default_nettype none

package nec_tx_pkg;

   localparam int FRAME_BITS_DEFAULT = 32;
   localparam int WORD_W             = 32;
   localparam int TICKS_W            = 16;
   localparam int CSR_INDEX_W        = 3;

   // item operation codes
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_CARRIER_DUTY      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MARK_TICKS        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ONE_SPACE_TICKS   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ZERO_SPACE_TICKS  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_START_MARK_TICKS  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_START_SPACE_TICKS = 3'd5;

   // register reset values
   localparam logic [TICKS_W-1:0] CARRIER_DUTY_RST      = 16'd0;
   localparam logic [TICKS_W-1:0] MARK_TICKS_RST        = 16'd560;
   localparam logic [TICKS_W-1:0] ONE_SPACE_TICKS_RST   = 16'd1690;
   localparam logic [TICKS_W-1:0] ZERO_SPACE_TICKS_RST  = 16'd560;
   localparam logic [TICKS_W-1:0] START_MARK_TICKS_RST  = 16'd9000;
   localparam logic [TICKS_W-1:0] START_SPACE_TICKS_RST = 16'd4500;

   typedef enum logic [5:0] {
      PH_IDLE        = 6'b000001,
      PH_START_MARK  = 6'b000010,
      PH_START_SPACE = 6'b000100,
      PH_BIT_MARK    = 6'b001000,
      PH_BIT_SPACE   = 6'b010000,
      PH_END_MARK    = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [TICKS_W-1:0] compare_value;
      logic               busy_res;
      logic               frame_done;
      logic               start_rejected;
   } result_type;

endpackage

`default_nettype wire

// ===== design/nec_ir_frame_transmitter.sv =====
// NEC IR frame transmitter: frame sequencer with registered result and skid stage.
// An accepted item's result is registered in the output or skid register.
// Throughput: one item per cycle while the skid entry is empty, one pass per item.
// A one-entry skid register keeps req_ready high for one item while rsp_ready is low.
// Reset (synchronous): phase idle, counters cleared, result stages empty,
// tick-length registers back to their defaults.
`timescale 1ns / 1ps
`default_nettype none

module nec_ir_frame_transmitter
   import nec_tx_pkg::*;
#(
   parameter int FRAME_BITS = FRAME_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_operation,
   input  wire logic [WORD_W-1:0]      req_frame_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [TICKS_W-1:0]          rsp_compare_value,
   output logic                        rsp_busy_res,
   output logic                        rsp_frame_done,
   output logic                        rsp_start_rejected,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [TICKS_W-1:0]     csr_wr_data
);

   localparam int BITS_W = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;
   localparam logic [BITS_W-1:0] BITS_INIT = BITS_W'(FRAME_BITS - 1);

   // a programmed length of zero behaves as one
   function automatic logic [TICKS_W-1:0] clamp_len(input logic [TICKS_W-1:0] len);
      clamp_len = (len == '0) ? TICKS_W'(1) : len;
   endfunction

   // configuration registers
   logic [TICKS_W-1:0] carrier_duty_ff, mark_ticks_ff, one_space_ticks_ff;
   logic [TICKS_W-1:0] zero_space_ticks_ff, start_mark_ticks_ff, start_space_ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         carrier_duty_ff      <= CARRIER_DUTY_RST;
         mark_ticks_ff        <= MARK_TICKS_RST;
         one_space_ticks_ff   <= ONE_SPACE_TICKS_RST;
         zero_space_ticks_ff  <= ZERO_SPACE_TICKS_RST;
         start_mark_ticks_ff  <= START_MARK_TICKS_RST;
         start_space_ticks_ff <= START_SPACE_TICKS_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_CARRIER_DUTY:      carrier_duty_ff      <= csr_wr_data;
            REG_MARK_TICKS:        mark_ticks_ff        <= csr_wr_data;
            REG_ONE_SPACE_TICKS:   one_space_ticks_ff   <= csr_wr_data;
            REG_ZERO_SPACE_TICKS:  zero_space_ticks_ff  <= csr_wr_data;
            REG_START_MARK_TICKS:  start_mark_ticks_ff  <= csr_wr_data;
            REG_START_SPACE_TICKS: start_space_ticks_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // frame state
   phase_type          phase_ff, phase_in;
   logic [TICKS_W-1:0] counter_ff, counter_in;
   logic [BITS_W-1:0]  bits_left_ff, bits_left_in;
   logic [WORD_W-1:0]  shift_word_ff, shift_word_in;

   // result stages
   result_type res_new, out_ff, out_in, skid_ff, skid_in;
   logic       out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   logic               accept;
   logic               done;
   logic               rejected;
   logic               in_mark;
   logic [TICKS_W-1:0] cnt_dec;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign cnt_dec   = counter_ff - TICKS_W'(1);

   always_comb begin
      phase_in      = phase_ff;
      counter_in    = counter_ff;
      bits_left_in  = bits_left_ff;
      shift_word_in = shift_word_ff;
      done          = 1'b0;
      rejected      = 1'b0;
      if (accept) begin
         if (req_operation == OP_START) begin
            if (phase_ff != PH_IDLE) begin
               rejected = 1'b1;
            end else begin
               shift_word_in = req_frame_data;
               bits_left_in  = BITS_INIT;
               phase_in      = PH_START_MARK;
               counter_in    = clamp_len(start_mark_ticks_ff);
            end
         end else if (phase_ff != PH_IDLE) begin
            counter_in = cnt_dec;
            if (cnt_dec == '0) begin
               case (phase_ff)
                  PH_START_MARK: begin
                     phase_in   = PH_START_SPACE;
                     counter_in = clamp_len(start_space_ticks_ff);
                  end
                  PH_START_SPACE: begin
                     phase_in   = PH_BIT_MARK;
                     counter_in = clamp_len(mark_ticks_ff);
                  end
                  PH_BIT_MARK: begin
                     phase_in      = PH_BIT_SPACE;
                     counter_in    = shift_word_ff[WORD_W-1] ? clamp_len(one_space_ticks_ff)
                                                             : clamp_len(zero_space_ticks_ff);
                     shift_word_in = {shift_word_ff[WORD_W-2:0], 1'b0};
                  end
                  PH_BIT_SPACE: begin
                     phase_in   = (bits_left_ff != '0) ? PH_BIT_MARK : PH_END_MARK;
                     counter_in = clamp_len(mark_ticks_ff);
                     if (bits_left_ff != '0) begin
                        bits_left_in = bits_left_ff - BITS_W'(1);
                     end
                  end
                  PH_END_MARK: begin
                     phase_in   = PH_IDLE;
                     counter_in = '0;
                     done       = 1'b1;
                  end
                  default: begin
                     phase_in   = PH_IDLE;
                     counter_in = '0;
                  end
               endcase
            end
         end
      end

      in_mark = (phase_in == PH_START_MARK) || (phase_in == PH_BIT_MARK) ||
                (phase_in == PH_END_MARK);
      res_new.compare_value  = in_mark ? carrier_duty_ff : '0;
      res_new.busy_res       = (phase_in != PH_IDLE);
      res_new.frame_done     = done;
      res_new.start_rejected = rejected;
   end

   // output register backed by one skid entry
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = res_new;
            out_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = res_new;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         counter_ff    <= '0;
         bits_left_ff  <= '0;
         shift_word_ff <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         counter_ff    <= counter_in;
         bits_left_ff  <= bits_left_in;
         shift_word_ff <= shift_word_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_compare_value  = out_ff.compare_value;
   assign rsp_busy_res       = out_ff.busy_res;
   assign rsp_frame_done     = out_ff.frame_done;
   assign rsp_start_rejected = out_ff.start_rejected;

   // skid entry only fills behind a held output
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid while output register empty");

   // counter is zero exactly when idle
   a_counter_idle: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) == (counter_ff == '0))
      else $error("phase counter out of step with phase");

   // a rejected start never changes the running frame
   a_reject_keeps_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_start_rejected |-> rsp_busy_res)
      else $error("rejected start shown while not busy");

   // frame completion returns to idle with the carrier off
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      accept && done |=> phase_ff == PH_IDLE && counter_ff == '0)
      else $error("frame done without return to idle");

   // a stalled item lands in the skid entry
   a_stall_to_skid: assert property (@(posedge clock) disable iff (reset)
      accept && out_valid_ff && !rsp_ready |=> skid_valid_ff)
      else $error("item accepted under stall was dropped");

endmodule

`default_nettype wire

// ===== tb/nec_ir_frame_transmitter_test.sv =====
// Self-checking testbench for the NEC IR frame transmitter.
`timescale 1ns / 1ps

module nec_ir_frame_transmitter_test;
   import nec_tx_pkg::*;

   localparam int RESET_CYCLES    = 9;
   localparam int CYCLE_LIMIT     = 2_000_000;
   localparam int RANDOM_PHASES   = 7;
   localparam int ITEMS_PER_PHASE = 140;

   typedef struct {
      logic              op;
      logic [WORD_W-1:0] data;
   } frame_item_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_operation = OP_TICK;
   logic [WORD_W-1:0]      req_frame_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [TICKS_W-1:0]     rsp_compare_value;
   logic                   rsp_busy_res;
   logic                   rsp_frame_done;
   logic                   rsp_start_rejected;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = REG_CARRIER_DUTY;
   logic [TICKS_W-1:0]     csr_wr_data = '0;

   // transmitter shadow state
   logic [TICKS_W-1:0] timing_regs [0:5];
   phase_type          tx_phase = PH_IDLE;
   logic [TICKS_W-1:0] tx_count = '0;
   logic [5:0]         tx_bits_left = '0;
   logic [WORD_W-1:0]  tx_word = '0;

   frame_item_type pending_items[$];
   result_type     expected_outputs[$];

   logic req_taken = 1'b0;
   int   failures = 0;
   int   results_seen = 0;
   int   cycle_count = 0;
   int   burst_left = 0;
   int   gap_left = 0;
   int   hold_left = 0;
   int   stall_mode = 0;
   int   stall_mode_left = 0;
   bit   long_hold_done = 1'b0;

   nec_ir_frame_transmitter DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_frame_data     (req_frame_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_compare_value  (rsp_compare_value),
      .rsp_busy_res       (rsp_busy_res),
      .rsp_frame_done     (rsp_frame_done),
      .rsp_start_rejected (rsp_start_rejected),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data)
   );

   always #6 clock = ~clock;

   function automatic void enter_tx_phase(phase_type next, logic [TICKS_W-1:0] len);
      tx_phase = next;
      tx_count = (len == '0) ? 16'd1 : len;
   endfunction

   // Advances the shadow transmitter by one item and returns the output it shows.
   function automatic result_type ir_output_after(logic op, logic [WORD_W-1:0] data);
      result_type out;
      logic       done_now;
      logic       rejected_now;
      done_now     = 1'b0;
      rejected_now = 1'b0;
      if (op == OP_START) begin
         if (tx_phase != PH_IDLE) begin
            rejected_now = 1'b1;
         end else begin
            tx_word      = data;
            tx_bits_left = 6'(FRAME_BITS_DEFAULT - 1);
            enter_tx_phase(PH_START_MARK, timing_regs[REG_START_MARK_TICKS]);
         end
      end else if (tx_phase != PH_IDLE) begin
         tx_count = tx_count - 16'd1;
         if (tx_count == '0) begin
            case (tx_phase)
               PH_START_MARK: enter_tx_phase(PH_START_SPACE, timing_regs[REG_START_SPACE_TICKS]);
               PH_START_SPACE: enter_tx_phase(PH_BIT_MARK, timing_regs[REG_MARK_TICKS]);
               PH_BIT_MARK: begin
                  enter_tx_phase(PH_BIT_SPACE, tx_word[WORD_W-1] ?
                                 timing_regs[REG_ONE_SPACE_TICKS] :
                                 timing_regs[REG_ZERO_SPACE_TICKS]);
                  tx_word = tx_word << 1;
               end
               PH_BIT_SPACE: begin
                  if (tx_bits_left != '0) begin
                     tx_bits_left = tx_bits_left - 6'd1;
                     enter_tx_phase(PH_BIT_MARK, timing_regs[REG_MARK_TICKS]);
                  end else begin
                     enter_tx_phase(PH_END_MARK, timing_regs[REG_MARK_TICKS]);
                  end
               end
               PH_END_MARK: begin
                  tx_phase = PH_IDLE;
                  tx_count = '0;
                  done_now = 1'b1;
               end
               default: begin
                  tx_phase = PH_IDLE;
                  tx_count = '0;
               end
            endcase
         end
      end
      out.compare_value  = (tx_phase == PH_START_MARK || tx_phase == PH_BIT_MARK ||
                            tx_phase == PH_END_MARK) ? timing_regs[REG_CARRIER_DUTY] : '0;
      out.busy_res       = (tx_phase != PH_IDLE);
      out.frame_done     = done_now;
      out.start_rejected = rejected_now;
      return out;
   endfunction

   // Sender: bursts of random length with random gaps.
   always @(negedge clock) begin : driver
      logic           valid_next;
      frame_item_type item;
      if (reset) begin
         valid_next = 1'b0;
      end else if (req_valid && !req_taken) begin
         valid_next = 1'b1;
      end else if (gap_left != 0) begin
         gap_left--;
         valid_next = 1'b0;
      end else if (pending_items.size() != 0) begin
         item = pending_items.pop_front();
         req_operation  <= item.op;
         req_frame_data <= item.data;
         valid_next = 1'b1;
         if (burst_left == 0)
            burst_left = $urandom_range(1, 24);
         burst_left--;
         if (burst_left == 0)
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end else begin
         valid_next = 1'b0;
      end
      req_valid <= valid_next;
   end

   // Receiver: own stall pattern plus long hold-offs that back up the block.
   always @(negedge clock) begin : receiver
      logic ready_next;
      if (hold_left != 0) begin
         hold_left--;
         ready_next = 1'b0;
      end else if (!long_hold_done && results_seen >= 400) begin
         long_hold_done = 1'b1;
         hold_left = 64;
         ready_next = 1'b0;
      end else if ($urandom_range(0, 1499) == 0) begin
         hold_left = $urandom_range(20, 80);
         ready_next = 1'b0;
      end else begin
         if (stall_mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_mode_left = $urandom_range(8, 64);
         end
         stall_mode_left--;
         case (stall_mode)
            0: ready_next = 1'b1;
            1: ready_next = ($urandom_range(0, 3) != 0);
            default: ready_next = $urandom_range(0, 1);
         endcase
      end
      rsp_ready <= ready_next;
   end

   always @(posedge clock) begin : monitor
      result_type want;
      req_taken <= req_valid && req_ready;
      // results first: an item accepted at this edge cannot have its result yet
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (expected_outputs.size() == 0) begin
            $error("result item with no expected output pending");
            failures++;
         end else begin
            want = expected_outputs.pop_front();
            if (rsp_compare_value !== want.compare_value) begin
               $error("compare_value: expected %0h, got %0h",
                      want.compare_value, rsp_compare_value);
               failures++;
            end
            if (rsp_busy_res !== want.busy_res) begin
               $error("busy_res: expected %0b, got %0b", want.busy_res, rsp_busy_res);
               failures++;
            end
            if (rsp_frame_done !== want.frame_done) begin
               $error("frame_done: expected %0b, got %0b", want.frame_done, rsp_frame_done);
               failures++;
            end
            if (rsp_start_rejected !== want.start_rejected) begin
               $error("start_rejected: expected %0b, got %0b",
                      want.start_rejected, rsp_start_rejected);
               failures++;
            end
         end
      end
      if (!reset && req_valid && req_ready)
         expected_outputs.push_back(ir_output_after(req_operation, req_frame_data));
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [TICKS_W-1:0] value);
      csr_index   = idx;
      csr_wr_data = value;
      csr_wr_en   = 1'b1;
      @(negedge clock);
      csr_wr_en = 1'b0;
      timing_regs[idx] = value;
   endtask

   task automatic set_timing(input logic [TICKS_W-1:0] duty, mark, one_space, zero_space,
                             start_mark, start_space);
      write_reg(REG_CARRIER_DUTY, duty);
      write_reg(REG_MARK_TICKS, mark);
      write_reg(REG_ONE_SPACE_TICKS, one_space);
      write_reg(REG_ZERO_SPACE_TICKS, zero_space);
      write_reg(REG_START_MARK_TICKS, start_mark);
      write_reg(REG_START_SPACE_TICKS, start_space);
   endtask

   task automatic queue_start(input logic [WORD_W-1:0] word);
      pending_items.push_back('{OP_START, word});
   endtask

   task automatic queue_ticks(input int count);
      repeat (count) pending_items.push_back('{OP_TICK, WORD_W'($urandom)});
   endtask

   // returns at a falling edge once no item is queued, offered or awaiting its result
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_items.size() != 0 || req_valid || expected_outputs.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      timing_regs[REG_CARRIER_DUTY]      = CARRIER_DUTY_RST;
      timing_regs[REG_MARK_TICKS]        = MARK_TICKS_RST;
      timing_regs[REG_ONE_SPACE_TICKS]   = ONE_SPACE_TICKS_RST;
      timing_regs[REG_ZERO_SPACE_TICKS]  = ZERO_SPACE_TICKS_RST;
      timing_regs[REG_START_MARK_TICKS]  = START_MARK_TICKS_RST;
      timing_regs[REG_START_SPACE_TICKS] = START_SPACE_TICKS_RST;
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // short phases, zero lengths count as one tick; full duty
      set_timing(16'hFFFF, 16'd1, 16'd2, 16'd0, 16'd1, 16'd0);
      queue_ticks(1);
      queue_start(32'hFFFF_FFFF);
      queue_start(32'h0000_0000);
      queue_ticks(100);
      wait_drained();

      write_reg(REG_CARRIER_DUTY, 16'h0000);
      queue_start(32'h0000_0000);
      queue_ticks(70);
      queue_start(32'hA5A5_5A5A);
      queue_start(32'hFFFF_FFFF);
      queue_ticks(110);
      wait_drained();

      // long start mark, with duty and mark length changed mid-frame
      set_timing(16'h8001, 16'd2, 16'd3, 16'd1, 16'd300, 16'd3);
      queue_start(32'h0F0F_3C3C);
      queue_ticks(200);
      wait_drained();
      write_reg(REG_CARRIER_DUTY, 16'hFFFF);
      write_reg(REG_MARK_TICKS, 16'd1);
      queue_start(32'h1234_5678);
      queue_ticks(300);
      wait_drained();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: set_timing(16'($urandom), 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
            1: set_timing(16'h0000, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
            2: set_timing(16'hFFFF, 16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                          16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                          16'($urandom_range(1, 6)));
            default: set_timing(16'($urandom), 16'($urandom_range(0, 6)),
                                16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
                                16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)));
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(0, 29) == 0)
               queue_start(WORD_W'($urandom));
            else
               queue_ticks(1);
         end
         wait_drained();
      end

      repeat (8) @(negedge clock);
      if (failures == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
